[hdl/ffga_pkg.sv]
// Shared types and constants for the first-fit granule allocator.
package ffga_pkg;

    localparam int GRAN_BYTES  = 16;
    localparam int GRAN_SHIFT  = 4;
    localparam int MAX_ENTRIES = 16;
    localparam int MAX_GRANULES = 4096;

    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int START_W = 12;
    localparam int SIZE_W  = 13;
    localparam int CAP_W   = 13;
    localparam int REQ_W   = 14;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_GRANULES);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_CHECK,
        S_A_SCAN,
        S_A_WRITE,
        S_F_CHECK,
        S_F_SCAN,
        S_F_SHIFT,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic        action;
        logic [16:0] amount_bytes;
        logic [15:0] block_offset;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] granted_offset;
        logic [16:0] used_bytes;
        logic [4:0]  live_entries;
    } rsp_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } entry_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_sts_t;

endpackage

[hdl/first_fit_granule_allocator.sv]
// Top level: request and result channels, capacity register, result register.
//
//  channel  signals                      dir  payload
//  request  req_valid, req_stall, req    in   action, amount_bytes, block_offset
//  result   rsp_valid, rsp_stall, rsp    out  status, granted_offset, used_bytes,
//                                              live_entries
//  config   cfg_we, cfg_data             in   capacity_granules
//
// Allocate runs a first-fit search that reads one table entry per cycle from the entry
// RAM, n live entries per pass, p passes (at most n+1).
// Free searches up to the match, then shifts the later entries down one slot each cycle.
// Reset clears the entry count, used total and capacity (4096); no clearing pass.
// A finished result waits in the output register while the next item is taken.
module first_fit_granule_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  ffga_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output ffga_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic [ffga_pkg::CAP_W-1:0] cfg_data
);

    logic [ffga_pkg::CAP_W-1:0] cap_reg;
    logic                       rsp_valid_reg, rsp_valid_next;
    ffga_pkg::rsp_t             rsp_reg, rsp_next;
    ffga_pkg::eng_ctl_t         ctl;
    ffga_pkg::eng_sts_t         sts;
    ffga_pkg::rsp_t             res;

    ffga_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cap   (cap_reg),
        .ctl   (ctl),
        .req   (req),
        .sts   (sts),
        .res   (res)
    );

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= ffga_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // handshake: take an item when idle, hand over a result when the slot frees
    always_comb
    begin
        ctl.start      = req_valid && sts.idle;
        ctl.ack        = sts.done && (!rsp_valid_reg || !rsp_stall);
        req_stall      = !sts.idle;
        rsp_next       = ctl.ack ? res : rsp_reg;
        if (ctl.ack)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hdl/ffga_ram.sv]
// Generic simple dual-port RAM with registered read data.
module ffga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ffga_engine.sv]
// Allocation table sequencer: first-fit search, append and free with compaction.
module ffga_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ffga_pkg::CAP_W-1:0]   cap,
    input  ffga_pkg::eng_ctl_t           ctl,
    input  ffga_pkg::req_t               req,
    output ffga_pkg::eng_sts_t           sts,
    output ffga_pkg::rsp_t               res
);

    ffga_pkg::fsm_t                   state_reg, state_next;
    ffga_pkg::req_t                   req_reg, req_next;
    logic [ffga_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ffga_pkg::CAP_W-1:0]       used_reg, used_next;
    logic [ffga_pkg::CAP_W-1:0]       s_reg, s_next;
    logic [ffga_pkg::REQ_W-1:0]       size_reg, size_next;
    logic [ffga_pkg::IDX_W-1:0]       k_reg, k_next;
    logic [ffga_pkg::CNT_W-1:0]       clean_reg, clean_next;
    ffga_pkg::status_t                stat_reg, stat_next;
    logic [15:0]                      grant_reg, grant_next;

    logic [ffga_pkg::IDX_W-1:0]       rd_addr;
    logic [ffga_pkg::IDX_W-1:0]       wr_addr;
    logic                             wr_en;
    ffga_pkg::entry_t                 wr_data;
    ffga_pkg::entry_t                 rd_data;

    logic [ffga_pkg::CAP_W-1:0]       cap_eff;
    logic [ffga_pkg::CAP_W-1:0]       avail;
    logic [ffga_pkg::REQ_W-1:0]       size_calc;
    logic [ffga_pkg::REQ_W-1:0]       ent_end;
    logic                             hit;
    logic                             match;
    logic [ffga_pkg::CNT_W-1:0]       k_inc;
    logic [ffga_pkg::IDX_W-1:0]       k_wrap;
    logic [ffga_pkg::CNT_W-1:0]       clean_inc;

    // entry table
    ffga_ram #(
        .WIDTH ($bits(ffga_pkg::entry_t)),
        .DEPTH (ffga_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // region size, free total and request size in granules
    always_comb
    begin
        cap_eff   = (cap > ffga_pkg::CAP_RESET) ? ffga_pkg::CAP_RESET : cap;
        avail     = (cap_eff > used_reg) ? (cap_eff - used_reg) : '0;
        size_calc = ffga_pkg::REQ_W'((18'(req_reg.amount_bytes)
                    + 18'(ffga_pkg::GRAN_BYTES - 1)) >> ffga_pkg::GRAN_SHIFT);
    end

    // entry compare against the current candidate start
    always_comb
    begin
        ent_end   = ffga_pkg::REQ_W'(rd_data.start) + ffga_pkg::REQ_W'(rd_data.size);
        hit       = (ffga_pkg::REQ_W'(s_reg) < ent_end) &&
                    (15'(rd_data.start) < (15'(s_reg) + 15'(size_reg)));
        match     = (req_reg.block_offset[ffga_pkg::GRAN_SHIFT-1:0] == '0) &&
                    (rd_data.start == req_reg.block_offset[15:ffga_pkg::GRAN_SHIFT]);
        k_inc     = ffga_pkg::CNT_W'(k_reg) + 1'b1;
        k_wrap    = (k_inc == cnt_reg) ? '0 : k_inc[ffga_pkg::IDX_W-1:0];
        clean_inc = clean_reg + 1'b1;
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffga_pkg::S_IDLE;
            cnt_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        s_reg     <= s_next;
        size_reg  <= size_next;
        k_reg     <= k_next;
        clean_reg <= clean_next;
        stat_reg  <= stat_next;
        grant_reg <= grant_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        used_next  = used_reg;
        s_next     = s_reg;
        size_next  = size_reg;
        k_next     = k_reg;
        clean_next = clean_reg;
        stat_next  = stat_reg;
        grant_next = grant_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = rd_data;
        sts.idle   = 1'b0;
        sts.done   = 1'b0;

        unique case (state_reg)
            ffga_pkg::S_IDLE:
            begin
                sts.idle = 1'b1;
                if (ctl.start)
                begin
                    req_next   = req;
                    grant_next = '0;
                    state_next = (req.action == ffga_pkg::ACT_ALLOC) ?
                                 ffga_pkg::S_A_CHECK : ffga_pkg::S_F_CHECK;
                end
            end

            ffga_pkg::S_A_CHECK:
            begin
                size_next  = size_calc;
                s_next     = '0;
                k_next     = '0;
                clean_next = '0;
                if (size_calc > ffga_pkg::REQ_W'(avail))
                begin
                    stat_next  = ffga_pkg::ST_NO_SPACE;
                    state_next = ffga_pkg::S_DONE;
                end
                else if (cnt_reg >= ffga_pkg::CNT_W'(ffga_pkg::MAX_ENTRIES))
                begin
                    stat_next  = ffga_pkg::ST_TABLE_FULL;
                    state_next = ffga_pkg::S_DONE;
                end
                else if (cap_eff == '0)
                begin
                    stat_next  = ffga_pkg::ST_NO_SPACE;
                    state_next = ffga_pkg::S_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ffga_pkg::S_A_WRITE;
                end
                else
                begin
                    state_next = ffga_pkg::S_A_SCAN;
                end
            end

            ffga_pkg::S_A_SCAN:
            begin
                // jump past a hit entry, stop once every entry has passed in a row
                if (hit)
                begin
                    clean_next = 5'd1;
                    if ((ent_end >= ffga_pkg::REQ_W'(cap_eff)) ||
                        ((15'(ent_end) + 15'(size_reg)) > 15'(cap_eff)))
                    begin
                        stat_next  = ffga_pkg::ST_NO_SPACE;
                        state_next = ffga_pkg::S_DONE;
                    end
                    else
                    begin
                        s_next = ent_end[ffga_pkg::CAP_W-1:0];
                        if (cnt_reg == 5'd1)
                        begin
                            state_next = ffga_pkg::S_A_WRITE;
                        end
                    end
                end
                else
                begin
                    clean_next = clean_inc;
                    if (clean_inc == cnt_reg)
                    begin
                        state_next = ffga_pkg::S_A_WRITE;
                    end
                end
                rd_addr = k_wrap;
                k_next  = k_wrap;
            end

            ffga_pkg::S_A_WRITE:
            begin
                wr_en         = 1'b1;
                wr_addr       = cnt_reg[ffga_pkg::IDX_W-1:0];
                wr_data.start = s_reg[ffga_pkg::START_W-1:0];
                wr_data.size  = size_reg[ffga_pkg::SIZE_W-1:0];
                cnt_next      = cnt_reg + 1'b1;
                used_next     = used_reg + size_reg[ffga_pkg::CAP_W-1:0];
                stat_next     = ffga_pkg::ST_OK;
                grant_next    = 16'(s_reg) << ffga_pkg::GRAN_SHIFT;
                state_next    = ffga_pkg::S_DONE;
            end

            ffga_pkg::S_F_CHECK:
            begin
                k_next = '0;
                if (cnt_reg == '0)
                begin
                    stat_next  = ffga_pkg::ST_NOT_FOUND;
                    state_next = ffga_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffga_pkg::S_F_SCAN;
                end
            end

            ffga_pkg::S_F_SCAN:
            begin
                rd_addr = k_inc[ffga_pkg::IDX_W-1:0];
                if (match)
                begin
                    used_next  = used_reg - rd_data.size;
                    stat_next  = ffga_pkg::ST_OK;
                    state_next = ffga_pkg::S_F_SHIFT;
                end
                else if (k_inc == cnt_reg)
                begin
                    stat_next  = ffga_pkg::ST_NOT_FOUND;
                    state_next = ffga_pkg::S_DONE;
                end
                else
                begin
                    k_next = k_inc[ffga_pkg::IDX_W-1:0];
                end
            end

            ffga_pkg::S_F_SHIFT:
            begin
                // move the next entry down one slot to close the gap
                if (k_inc < cnt_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = k_reg;
                    rd_addr = k_reg + 2'd2;
                    k_next  = k_inc[ffga_pkg::IDX_W-1:0];
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ffga_pkg::S_DONE;
                end
            end

            ffga_pkg::S_DONE:
            begin
                sts.done = 1'b1;
                if (ctl.ack)
                begin
                    state_next = ffga_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffga_pkg::S_IDLE;
            end
        endcase
    end

    // result item
    always_comb
    begin
        res.status         = stat_reg;
        res.granted_offset = grant_reg;
        res.used_bytes     = 17'(used_reg) << ffga_pkg::GRAN_SHIFT;
        res.live_entries   = cnt_reg;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ffga_pkg::CNT_W'(ffga_pkg::MAX_ENTRIES))
        else $error("entry count above table depth");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffga_pkg::S_A_SCAN) |-> (s_reg < cap_eff))
        else $error("candidate start outside region during scan");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffga_pkg::S_A_WRITE) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("append did not grow the table");

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffga_pkg::S_A_WRITE) |=> (used_reg <= ffga_pkg::CAP_RESET))
        else $error("used total beyond largest region");
`endif

endmodule

[bench/first_fit_granule_allocator_tb.sv]
// Testbench for the first-fit granule allocator: queued stimulus, predicted results, random idling.
module first_fit_granule_allocator_tb;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ffga_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ffga_pkg::rsp_t rsp;
    logic cfg_we;
    logic [ffga_pkg::CAP_W-1:0] cfg_data;

    first_fit_granule_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Allocator image kept by the bench
    int unsigned cap_gran;
    int unsigned tbl_start[ffga_pkg::MAX_ENTRIES];
    int unsigned tbl_size[ffga_pkg::MAX_ENTRIES];
    int unsigned tbl_count;
    int unsigned used_gran;

    ffga_pkg::req_t pending_reqs[$];
    ffga_pkg::rsp_t expected_rsps[$];
    int errors;
    int hold_cycles;
    bit drain_hold;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("** first_fit_granule_allocator: FAILED **");
        $finish;
    end

    function automatic bit span_taken(int unsigned s, int unsigned sz);
        for (int k = 0; k < tbl_count; k++)
            if (s < tbl_start[k] + tbl_size[k] && tbl_start[k] < s + sz)
                return 1'b1;
        return 1'b0;
    endfunction

    // Apply one request to the image and return the expected result
    function automatic ffga_pkg::rsp_t apply_request(ffga_pkg::req_t r);
        ffga_pkg::rsp_t o;
        int unsigned region, avail, sz, off;
        ffga_pkg::status_t st;
        bit placed;
        off = 0;
        st = ffga_pkg::ST_NO_SPACE;
        if (r.action == ffga_pkg::ACT_ALLOC)
        begin
            region = (cap_gran > ffga_pkg::MAX_GRANULES) ? ffga_pkg::MAX_GRANULES : cap_gran;
            avail = (region > used_gran) ? region - used_gran : 0;
            sz = (r.amount_bytes + ffga_pkg::GRAN_BYTES - 1) / ffga_pkg::GRAN_BYTES;
            if (sz > avail)
                st = ffga_pkg::ST_NO_SPACE;
            else if (tbl_count >= ffga_pkg::MAX_ENTRIES)
                st = ffga_pkg::ST_TABLE_FULL;
            else
            begin
                placed = 1'b0;
                for (int unsigned s = 0; s < region && !placed; s++)
                begin
                    if (s + sz > region)
                        break;
                    if (!span_taken(s, sz))
                    begin
                        tbl_start[tbl_count] = s;
                        tbl_size[tbl_count] = sz;
                        tbl_count++;
                        used_gran += sz;
                        off = s * ffga_pkg::GRAN_BYTES;
                        st = ffga_pkg::ST_OK;
                        placed = 1'b1;
                    end
                end
            end
        end
        else
        begin
            st = ffga_pkg::ST_NOT_FOUND;
            for (int k = 0; k < tbl_count; k++)
            begin
                if (tbl_start[k] * ffga_pkg::GRAN_BYTES == r.block_offset)
                begin
                    used_gran -= tbl_size[k];
                    tbl_count--;
                    for (int j = k; j < tbl_count; j++)
                    begin
                        tbl_start[j] = tbl_start[j + 1];
                        tbl_size[j] = tbl_size[j + 1];
                    end
                    st = ffga_pkg::ST_OK;
                    break;
                end
            end
        end
        o.status = st;
        o.granted_offset = 16'(off);
        o.used_bytes = 17'(used_gran * ffga_pkg::GRAN_BYTES);
        o.live_entries = 5'(tbl_count);
        return o;
    endfunction

    function automatic ffga_pkg::req_t mk_alloc(int unsigned bytes);
        ffga_pkg::req_t r;
        r.action = ffga_pkg::ACT_ALLOC;
        r.amount_bytes = 17'(bytes);
        r.block_offset = 16'($urandom);
        return r;
    endfunction

    function automatic ffga_pkg::req_t mk_free(int unsigned off);
        ffga_pkg::req_t r;
        r.action = ffga_pkg::ACT_FREE;
        r.amount_bytes = 17'($urandom);
        r.block_offset = 16'(off);
        return r;
    endfunction

    // Random request, mostly small allocs and frees of live offsets
    function automatic ffga_pkg::req_t rand_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return mk_alloc(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65536)
                                                        : $urandom_range(0, 2048));
        else if (sel < 85 && tbl_count > 0)
            return mk_free(tbl_start[$urandom_range(0, tbl_count - 1)] *
                           ffga_pkg::GRAN_BYTES);
        else
            return mk_free($urandom_range(0, 65535));
    endfunction

    // Driver: offer queued items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || !req_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver stall: random gaps, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
        end
        else if (drain_hold)
        begin
            hold_cycles <= 300;
            drain_hold <= 1'b0;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            ffga_pkg::rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result %p", rsp);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp.status != e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_offset != e.granted_offset)
                begin
                    $error("granted_offset exp %0d got %0d", e.granted_offset,
                           rsp.granted_offset);
                    errors++;
                end
                if (rsp.used_bytes != e.used_bytes)
                begin
                    $error("used_bytes exp %0d got %0d", e.used_bytes, rsp.used_bytes);
                    errors++;
                end
                if (rsp.live_entries != e.live_entries)
                begin
                    $error("live_entries exp %0d got %0d", e.live_entries,
                           rsp.live_entries);
                    errors++;
                end
            end
        end
    end

    task automatic queue_req(ffga_pkg::req_t r);
        expected_rsps.push_back(apply_request(r));
        pending_reqs.push_back(r);
    endtask

    task automatic drain(int limit);
        int n;
        n = 0;
        while ((pending_reqs.size() > 0 || expected_rsps.size() > 0) && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        if (n >= limit)
        begin
            $display("** first_fit_granule_allocator: FAILED **");
            $finish;
        end
        repeat (600) @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= ffga_pkg::CAP_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_gran = v;
    endtask

    initial
    begin
        int unsigned caps[6];
        caps = '{0, 1, 5, 100, 4096, 8191};
        errors = 0;
        hold_cycles = 0;
        drain_hold = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cap_gran = ffga_pkg::MAX_GRANULES;
        tbl_count = 0;
        used_gran = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, zero-size, full table, unknown and misaligned frees
        queue_req(mk_alloc(0));
        queue_req(mk_alloc(65536));
        queue_req(mk_alloc(1));
        queue_req(mk_alloc(17));
        queue_req(mk_free(0));
        queue_req(mk_alloc(0));
        queue_req(mk_free(65535));
        queue_req(mk_free(8));
        for (int i = 0; i < 15; i++)
            queue_req(mk_alloc(16));
        queue_req(mk_alloc(16));
        queue_req(mk_free(16));
        // Let the long receiver hold fill the block while items keep coming
        hold_cycles = 400;
        drain(200000);

        // Sender pauses until every result is in, then random phases per capacity
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            for (int i = 0; i < 170; i++)
            begin
                queue_req(rand_request());
                if (i == 60 && p == 2)
                    drain_hold = 1'b1;
            end
            drain(400000);
        end
        // Used above capacity: shrink while blocks are live
        write_capacity(4096);
        for (int i = 0; i < 8; i++)
            queue_req(mk_alloc(4096));
        drain(200000);
        write_capacity(10);
        queue_req(mk_alloc(16));
        queue_req(mk_alloc(0));
        queue_req(mk_free(0));
        drain(200000);

        if (errors == 0)
            $display("** first_fit_granule_allocator: PASSED **");
        else
            $display("** first_fit_granule_allocator: FAILED **");
        $finish;
    end
endmodule

[filelist.f]
hdl/ffga_pkg.sv
hdl/ffga_ram.sv
hdl/ffga_engine.sv
hdl/first_fit_granule_allocator.sv
bench/first_fit_granule_allocator_tb.sv
